>>> design/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg - envelope segment sequencer shared definitions
// Segment codes, configuration register indexes and stream field widths.
// ----------------------------------------------------------------------------
package ess_pkg;

  // Segment codes (state of the envelope sequencer)
  localparam int unsigned SEG_W = 3;
  localparam logic [SEG_W-1:0] SEG_IDLE     = 3'd0;
  localparam logic [SEG_W-1:0] SEG_ATTACK   = 3'd1;
  localparam logic [SEG_W-1:0] SEG_DECAY1   = 3'd2;
  localparam logic [SEG_W-1:0] SEG_DECAY2   = 3'd3;
  localparam logic [SEG_W-1:0] SEG_SUSTAIN  = 3'd4;
  localparam logic [SEG_W-1:0] SEG_RELEASE  = 3'd5;
  localparam logic [SEG_W-1:0] SEG_FINISHED = 3'd6;

  // Segment length registers are 24 bits
  localparam int unsigned LEN_W = 24;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = LEN_W;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd4;

  // Stream widths
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_USED_W = SEG_W + ELAPSED_W + LEN_W;

endpackage

>>> design/envelope_segment_sequencer.sv
// Output: results appear on the master side in the cycle after a tick request is taken.
// Throughput: one tick per cycle; ready drops only while the output register holds a
//   result that downstream has not taken.
// Reset (rst_ni low, asynchronous): segment idle, tick counter, elapsed and length cleared,
//   all timing registers and the two-segment mode flag cleared, output empty.
// ----------------------------------------------------------------------------
// envelope_segment_sequencer - ADSR style segment timing control
// Walks attack / decay1 / decay2 / sustain / release / finished on a saturating
// tick counter, checking the key only on the first tick of each buffer.
// ----------------------------------------------------------------------------
module envelope_segment_sequencer #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [ess_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ess_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Tick requests
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] key_on, [1] frame_start, [7:2] zero
  input  logic [ess_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Segment results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] segment, [34:3] elapsed_ticks, [58:35] segment_length, [63:59] zero
  output logic [ess_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ess_pkg::*;

  // Width used for comparing counter values against 24-bit lengths
  localparam int unsigned CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  // Configuration registers
  logic [LEN_W-1:0] attack_q, decay1_q, decay2_q, release_q;
  logic             mode_q;

  // Sequencer state. Instead of start/target we keep the distance from the
  // segment start (elapsed) and the segment length; target - start fits 24 bits.
  logic [SEG_W-1:0]       seg_q, seg_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] el_q, el_d;
  logic [LEN_W-1:0]       sl_q, sl_d;

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic in_acc;

  // Intermediate values
  logic                   key_on, frame_start;
  logic                   key_start, key_stop, key_hit;
  logic [COUNT_WIDTH-1:0] cnt1;
  logic                   cnt1_max;
  logic [LEN_W-1:0]       len_k, len_e;
  logic [SEG_W-1:0]       seg1, seg_n, seg_f;
  logic [LEN_W-1:0]       sl1, sl_f, len_out;
  logic [COUNT_WIDTH-1:0] el1, el_f;
  logic                   reach, adv;

  // Segment length clipped so that start + length stays within the counter range
  function automatic logic [LEN_W-1:0] fit_len(input logic [LEN_W-1:0] len,
                                               input logic [COUNT_WIDTH-1:0] cnt);
    logic [CMP_W-1:0] room;
    room = CMP_W'(~cnt);
    if (CMP_W'(len) <= room) begin
      return len;
    end
    return room[LEN_W-1:0];
  endfunction

  // Output register frees up whenever downstream takes its result
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // --------------------------------------------------------------------------
  // One tick: key check, end-of-segment check, result, counter increment
  // --------------------------------------------------------------------------
  always_comb begin
    key_on      = s_axis_tdata[0];
    frame_start = s_axis_tdata[1];

    // Key events only on the first tick of a buffer
    key_start = frame_start && key_on && (seg_q == SEG_IDLE);
    key_stop  = frame_start && !key_on &&
                (seg_q == SEG_ATTACK || seg_q == SEG_DECAY1 ||
                 seg_q == SEG_DECAY2 || seg_q == SEG_SUSTAIN);
    key_hit   = key_start || key_stop;

    // Key-on restarts the counter from zero
    cnt1     = key_start ? '0 : cnt_q;
    cnt1_max = &cnt1;
    len_k    = key_start ? attack_q : release_q;

    seg1 = key_start ? SEG_ATTACK : (key_stop ? SEG_RELEASE : seg_q);
    sl1  = key_hit ? fit_len(len_k, cnt1) : sl_q;
    el1  = key_hit ? '0 : el_q;

    // Freshly entered segment ends at once on zero length or a pinned counter
    reach = key_hit ? ((len_k == '0) || cnt1_max)
                    : (CMP_W'(el_q) >= CMP_W'(sl_q));

    // Successor segment; decays hold in two-segment mode until key-off
    adv   = 1'b0;
    seg_n = seg1;
    len_e = '0;
    unique case (seg1)
      SEG_ATTACK: begin
        adv   = 1'b1;
        seg_n = mode_q ? SEG_SUSTAIN : SEG_DECAY1;
        len_e = mode_q ? '0 : decay1_q;
      end
      SEG_DECAY1: begin
        adv   = !mode_q;
        seg_n = SEG_DECAY2;
        len_e = decay2_q;
      end
      SEG_DECAY2: begin
        adv   = !mode_q;
        seg_n = SEG_SUSTAIN;
      end
      SEG_RELEASE: begin
        adv   = 1'b1;
        seg_n = SEG_FINISHED;
      end
      default: begin
        adv = 1'b0;
      end
    endcase
    adv = adv && reach;

    seg_f = adv ? seg_n : seg1;
    sl_f  = adv ? fit_len(len_e, cnt1) : sl1;
    el_f  = adv ? '0 : el1;

    // Steady segments report zero length
    len_out = (seg_f == SEG_IDLE || seg_f == SEG_SUSTAIN || seg_f == SEG_FINISHED)
              ? '0 : sl_f;

    // Saturating count; elapsed stops with it
    cnt_d = cnt1_max ? cnt1 : cnt1 + 1'b1;
    el_d  = cnt1_max ? el_f : el_f + 1'b1;
    seg_d = seg_f;
    sl_d  = sl_f;

    m_data_d = OUT_TDATA_W'({len_out, ELAPSED_W'(el_f), seg_f});
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay1_q  <= '0;
      decay2_q  <= '0;
      release_q <= '0;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK:  attack_q  <= cfg_wdata_i;
        REG_DECAY1:  decay1_q  <= cfg_wdata_i;
        REG_DECAY2:  decay2_q  <= cfg_wdata_i;
        REG_RELEASE: release_q <= cfg_wdata_i;
        REG_MODE:    mode_q    <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q     <= SEG_IDLE;
      cnt_q     <= '0;
      el_q      <= '0;
      sl_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        seg_q <= seg_d;
        cnt_q <= cnt_d;
        el_q  <= el_d;
        sl_q  <= sl_d;
      end
      if (in_acc) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_data_q <= m_data_d;
    end
  end

`ifndef SYNTHESIS
  // Finished is terminal
  a_finished_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q == SEG_FINISHED |=> seg_q == SEG_FINISHED)
    else $error("finished segment left");

  // Once keyed, the sequencer never returns to idle
  a_no_idle_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q != SEG_IDLE |=> seg_q != SEG_IDLE)
    else $error("returned to idle");

  // Steady segments carry no length
  a_steady_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q == SEG_IDLE || seg_q == SEG_SUSTAIN || seg_q == SEG_FINISHED) |-> sl_q == '0)
    else $error("steady segment with nonzero length");

  // Segment start never lies after the current count
  a_elapsed_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    el_q <= cnt_q)
    else $error("elapsed exceeds tick count");

  // A taken request always yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_valid_q)
    else $error("request taken without result");
`endif

endmodule

>>> bench/envelope_segment_sequencer_test.sv
// ----------------------------------------------------------------------------
// envelope_segment_sequencer_test - segment timing regression
// Drives sample tick requests with random idling on both stream sides, tracks
// the expected segment, elapsed and length for every tick in a scoreboard and
// walks one full envelope: idle, attack, decay1, decay2, sustain, release and
// finished, with register changes between phases.
// ----------------------------------------------------------------------------
module envelope_segment_sequencer_test;
  import ess_pkg::*;

  localparam int unsigned COUNT_W = 32;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  // Indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [SEG_W-1:0]     segment;
    logic [ELAPSED_W-1:0] elapsed;
    logic [LEN_W-1:0]     seg_len;
  } segment_result_t;

  // Tracks the envelope state and queues the result every tick should give
  class segment_scoreboard;
    logic [LEN_W-1:0]   attack_len, decay1_len, decay2_len, release_len;
    bit                 two_segment;
    logic [SEG_W-1:0]   segment;
    logic [COUNT_W-1:0] count, seg_start, seg_target;
    segment_result_t    pending[$];
    int unsigned        errors;

    function new();
      attack_len  = '0;
      decay1_len  = '0;
      decay2_len  = '0;
      release_len = '0;
      two_segment = 1'b0;
      segment     = SEG_IDLE;
      count       = '0;
      seg_start   = '0;
      seg_target  = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ATTACK:  attack_len  = value;
        REG_DECAY1:  decay1_len  = value;
        REG_DECAY2:  decay2_len  = value;
        REG_RELEASE: release_len = value;
        REG_MODE:    two_segment = value[0];
        default: ;
      endcase
    endfunction

    // Target saturates at the counter maximum
    function void enter(logic [SEG_W-1:0] code, logic [LEN_W-1:0] len);
      logic [COUNT_W:0] sum;
      sum        = {1'b0, count} + len;
      segment    = code;
      seg_start  = count;
      seg_target = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    function void note_tick(bit key_on, bit frame_start);
      segment_result_t    res;
      logic [COUNT_W-1:0] span;
      // key is looked at only on the first tick of a buffer
      if (frame_start) begin
        case (segment)
          SEG_IDLE: if (key_on) begin
            count = '0;
            enter(SEG_ATTACK, attack_len);
          end
          SEG_ATTACK, SEG_DECAY1, SEG_DECAY2, SEG_SUSTAIN:
            if (!key_on) enter(SEG_RELEASE, release_len);
          default: ;
        endcase
      end
      // at most one end-of-segment step per tick
      if (count >= seg_target) begin
        case (segment)
          SEG_RELEASE: enter(SEG_FINISHED, '0);
          SEG_ATTACK: begin
            if (two_segment) enter(SEG_SUSTAIN, '0);
            else enter(SEG_DECAY1, decay1_len);
          end
          SEG_DECAY1: if (!two_segment) enter(SEG_DECAY2, decay2_len);
          SEG_DECAY2: if (!two_segment) enter(SEG_SUSTAIN, '0);
          default: ;
        endcase
      end
      span        = seg_target - seg_start;
      res.segment = segment;
      res.elapsed = count - seg_start;
      res.seg_len = (segment == SEG_IDLE || segment == SEG_SUSTAIN ||
                     segment == SEG_FINISHED) ? '0 : span[LEN_W-1:0];
      pending.push_back(res);
      if (count != '1) count++;
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      segment_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no tick outstanding: %h", word);
        return;
      end
      want = pending.pop_front();
      if (word[SEG_W-1:0] !== want.segment)
        report("segment", want.segment, word[SEG_W-1:0]);
      if (word[SEG_W +: ELAPSED_W] !== want.elapsed)
        report("elapsed_ticks", want.elapsed, word[SEG_W +: ELAPSED_W]);
      if (word[SEG_W+ELAPSED_W +: LEN_W] !== want.seg_len)
        report("segment_length", want.seg_len, word[SEG_W+ELAPSED_W +: LEN_W]);
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_idx_i;
  logic [CFG_DATA_W-1:0]        cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [IN_TDATA_W-1:0]        s_axis_tdata;   // [0] key_on, [1] frame_start
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [OUT_TDATA_W-1:0]       m_axis_tdata;   // segment, elapsed_ticks, segment_length

  segment_scoreboard tracker;
  bit                calm;        // set: no idling on either side
  int unsigned       stall_left;

  envelope_segment_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: ready drops for random stretches
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  // Called at a falling edge; register takes the write at the next rising edge
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.write_reg(idx, value);
  endtask

  // One tick request; valid stays up across back-to-back requests
  task automatic send_tick(input bit key_on, input bit frame_start);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = '0;
    s_axis_tdata[0] = key_on;
    s_axis_tdata[1] = frame_start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_tick(key_on, frame_start);
    @(negedge clk_i);
  endtask

  // Random tick; with pin_key the key on buffer starts is held at pin_level,
  // off-frame key values are noise the block must ignore
  task automatic send_random_tick(input bit pin_key, input bit pin_level);
    bit frame_start;
    bit key_on;
    frame_start = ($urandom_range(0, 3) == 0);
    key_on = 1'($urandom_range(0, 1));
    if (frame_start && pin_key) key_on = pin_level;
    send_tick(key_on, frame_start);
  endtask

  // Stop sending and let every outstanding result arrive
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ATTACK;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    calm          = 1'b0;
    tracker       = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Idle: every register at its top value, stray indexes dropped
    write_cfg(REG_ATTACK, LEN_MAX);
    write_cfg(REG_DECAY1, LEN_MAX);
    write_cfg(REG_DECAY2, LEN_MAX);
    write_cfg(REG_RELEASE, LEN_MAX);
    write_cfg(REG_MODE, CFG_DATA_W'(1));
    write_cfg(REG_UNMAPPED_LO, LEN_MAX);
    write_cfg(REG_UNMAPPED_HI, '0);
    // key-on off a buffer start must not start the envelope
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (140) send_random_tick(1'b1, 1'b0);
    drain();

    // Key on: counter cleared, attack 20 ticks then decay1 of 10
    write_cfg(REG_ATTACK, CFG_DATA_W'(20));
    write_cfg(REG_DECAY1, CFG_DATA_W'(10));
    write_cfg(REG_MODE, CFG_DATA_W'(0));
    send_tick(1'b1, 1'b1);
    repeat (24) send_random_tick(1'b1, 1'b1);
    drain();

    // Two-segment mode while in decay1: it overstays its target
    write_cfg(REG_MODE, CFG_DATA_W'(1));
    write_cfg(REG_ATTACK, '0);
    repeat (100) send_random_tick(1'b1, 1'b1);
    drain();

    // Back to four segments: decay1 ends at once, zero-length decay2, sustain
    write_cfg(REG_DECAY2, '0);
    write_cfg(REG_MODE, CFG_DATA_W'(0));
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    repeat (150) send_random_tick(1'b1, 1'b1);
    drain();
    calm = 1'b1;
    repeat (150) send_random_tick(1'b1, 1'b1);
    calm = 1'b0;
    drain();

    // Key off into a 50 tick release, then finished for good
    write_cfg(REG_RELEASE, CFG_DATA_W'(50));
    write_cfg(REG_DECAY1, LEN_MAX);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (180) send_random_tick(1'b0, 1'b0);
    drain();
    repeat (8) @(negedge clk_i);

    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
